>>> src/occupancy_grid_rect_placer_assert.svh
// Assertion macros used by the occupancy grid rectangle placer datapath.
`ifndef OCCUPANCY_GRID_RECT_PLACER_ASSERT_SVH
`define OCCUPANCY_GRID_RECT_PLACER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define OGRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define OGRP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/ogrp_pkg.sv
// Package with types, constants and codes of the occupancy grid rectangle placer.
`default_nettype none
package ogrp_pkg;

  localparam int COORD_W    = 16;
  localparam int DIM_W      = 15;
  localparam int CS_W       = 13;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int EXT_W      = 18;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int COL_W    = 6;
  localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam logic [DIM_W-1:0]    COL_LAST_Q = DIM_W'(MAX_COLS - 1);
  localparam logic [DIM_W-1:0]    ROW_LAST_Q = DIM_W'(MAX_ROWS - 1);
  localparam logic [MAX_COLS-1:0] COL_ONES   = '1;

  localparam int DIV_STEPS = DIM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_LEFT   = 3'd0,
    CFG_VIEW_TOP    = 3'd1,
    CFG_VIEW_WIDTH  = 3'd2,
    CFG_VIEW_HEIGHT = 3'd3,
    CFG_CELL_SIZE   = 3'd4
  } cfg_idx_t;

  typedef enum logic [STAT_W-1:0] {
    ST_PLACED    = 3'd0,
    ST_OUTSIDE   = 3'd1,
    ST_BLOCKED   = 3'd2,
    ST_CLEARED   = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    DIV_VW = 3'd0,
    DIV_VH = 3'd1,
    DIV_X0 = 3'd2,
    DIV_X1 = 3'd3,
    DIV_Y0 = 3'd4,
    DIV_Y1 = 3'd5
  } div_sel_t;

  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic        [DIM_W-1:0]   rect_width;
    logic        [DIM_W-1:0]   rect_height;
  } in_item_t;

  typedef struct packed {
    logic              shown;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic     cfg_write;
    logic     load_item;
    logic     clear_grid;
    logic     grid_bad;
    logic     div_start;
    div_sel_t div_sel;
    logic     sweep_start;
    logic     sweep_mark;
    logic     load_result;
    status_t  result;
  } ogrp_cmd_t;

  typedef struct packed {
    logic cfg_idx_ok;
    logic cs_zero;
    logic kind_clear;
    logic grid_ok;
    logic empty;
    logic miss;
    logic div_busy;
    logic div_done;
    logic sweep_busy;
    logic sweep_done;
    logic hit;
    logic out_free;
  } ogrp_stat_t;

endpackage
`default_nettype wire

>>> src/ogrp_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module ogrp_div (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [ogrp_pkg::DIM_W-1:0] dividend,
  input  wire  [ogrp_pkg::CS_W-1:0]  divisor,
  output logic                      busy,
  output logic                      done,
  output logic [ogrp_pkg::DIM_W-1:0] quotient
);
  import ogrp_pkg::*;

  logic                 run_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CS_W-1:0]      rem_r;
  logic [DIM_W-1:0]     quo_r;
  logic [CS_W:0]        shifted;
  logic [CS_W+1:0]      diff;
  logic                 fits;

  assign shifted = {rem_r, quo_r[DIM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, divisor};
  assign fits    = !diff[CS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start && !run_r && !done_r) begin
      run_r  <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS);
    end else if (run_r) begin
      cnt_r <= cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !run_r && !done_r) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= fits ? diff[CS_W-1:0] : shifted[CS_W-1:0];
      quo_r <= {quo_r[DIM_W-2:0], fits};
    end
  end

  assign busy     = run_r || done_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> src/ogrp_dp.sv
// Datapath: configuration, clipping, cell span, occupancy memory and result register.
`default_nettype none
`include "occupancy_grid_rect_placer_assert.svh"
module ogrp_dp (
  input  wire                             clk,
  input  wire                             rst_n,
  input  ogrp_pkg::in_item_t              in_data,
  input  wire  [ogrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ogrp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                             out_stall,
  output logic                            out_valid,
  output ogrp_pkg::out_item_t             out_data,
  input  ogrp_pkg::ogrp_cmd_t             cmd,
  output ogrp_pkg::ogrp_stat_t            st
);
  import ogrp_pkg::*;

  logic signed [COORD_W-1:0] view_left_r;
  logic signed [COORD_W-1:0] view_top_r;
  logic        [DIM_W-1:0]   view_width_r;
  logic        [DIM_W-1:0]   view_height_r;
  logic        [CS_W-1:0]    cell_size_r;

  in_item_t                item_r;
  logic signed [EXT_W-1:0] vl_ext, vt_ext, vw_ext, vh_ext;
  logic signed [EXT_W-1:0] rl_ext, rt_ext, rw_ext, rh_ext;
  logic signed [EXT_W-1:0] x1_rect, y1_rect, x1_view, y1_view;
  logic signed [EXT_W-1:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [EXT_W-1:0] ox0, ox1, oy0, oy1;

  logic                cfg_idx_ok;
  logic                grid_clr;
  logic [DIM_W-1:0]    div_a;
  logic                div_busy, div_done;
  logic [DIM_W-1:0]    div_q;
  logic [DIM_W:0]      div_q_inc;
  logic [DIM_W-1:0]    col_q_r;
  logic                grid_ok_r;
  logic [COL_W-1:0]    col_last_r;
  logic [ROW_W-1:0]    row_last_r;
  logic [COL_W-1:0]    c0_r, c1_r;
  logic [ROW_W-1:0]    r0_r, r1_r;
  logic [MAX_COLS-1:0] mask_r;

  logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] row_vld_r;
  logic [MAX_COLS-1:0] rdata_r;
  logic [MAX_COLS-1:0] occ_word;
  logic [ROW_W-1:0]    row_r, rd_row_r;
  logic                act_r, rd_vld_r, rd_last_r, hit_r, hit_now;

  logic                out_valid_r;
  out_item_t           out_data_r;

  // Configuration registers.
  always_comb begin
    unique case (cfg_index) inside
      CFG_VIEW_LEFT, CFG_VIEW_TOP, CFG_VIEW_WIDTH, CFG_VIEW_HEIGHT,
      CFG_CELL_SIZE: cfg_idx_ok = 1'b1;
      default:       cfg_idx_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_left_r   <= '0;
      view_top_r    <= '0;
      view_width_r  <= '0;
      view_height_r <= '0;
      cell_size_r   <= CS_W'(16);
    end else if (cmd.cfg_write) begin
      unique case (cfg_index)
        CFG_VIEW_LEFT:   view_left_r   <= cfg_data[COORD_W-1:0];
        CFG_VIEW_TOP:    view_top_r    <= cfg_data[COORD_W-1:0];
        CFG_VIEW_WIDTH:  view_width_r  <= cfg_data[DIM_W-1:0];
        CFG_VIEW_HEIGHT: view_height_r <= cfg_data[DIM_W-1:0];
        CFG_CELL_SIZE:   cell_size_r   <= cfg_data[CS_W-1:0];
        default: ;
      endcase
    end
  end

  // Item capture and clipping against the view.
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  assign vl_ext = {{(EXT_W-COORD_W){view_left_r[COORD_W-1]}}, view_left_r};
  assign vt_ext = {{(EXT_W-COORD_W){view_top_r[COORD_W-1]}}, view_top_r};
  assign vw_ext = {{(EXT_W-DIM_W){1'b0}}, view_width_r};
  assign vh_ext = {{(EXT_W-DIM_W){1'b0}}, view_height_r};
  assign rl_ext = {{(EXT_W-COORD_W){item_r.rect_left[COORD_W-1]}}, item_r.rect_left};
  assign rt_ext = {{(EXT_W-COORD_W){item_r.rect_top[COORD_W-1]}}, item_r.rect_top};
  assign rw_ext = {{(EXT_W-DIM_W){1'b0}}, item_r.rect_width};
  assign rh_ext = {{(EXT_W-DIM_W){1'b0}}, item_r.rect_height};

  assign x1_rect = rl_ext + rw_ext - EXT_W'(1);
  assign y1_rect = rt_ext + rh_ext - EXT_W'(1);
  assign x1_view = vl_ext + vw_ext - EXT_W'(1);
  assign y1_view = vt_ext + vh_ext - EXT_W'(1);

  always_ff @(posedge clk) begin
    x0_r <= (rl_ext > vl_ext) ? rl_ext : vl_ext;
    y0_r <= (rt_ext > vt_ext) ? rt_ext : vt_ext;
    x1_r <= (x1_view < x1_rect) ? x1_view : x1_rect;
    y1_r <= (y1_view < y1_rect) ? y1_view : y1_rect;
  end

  assign ox0 = x0_r - vl_ext;
  assign ox1 = x1_r - vl_ext;
  assign oy0 = y0_r - vt_ext;
  assign oy1 = y1_r - vt_ext;

  // Shared divider by the cell size.
  always_comb begin
    case (cmd.div_sel)
      DIV_VW:  div_a = view_width_r;
      DIV_VH:  div_a = view_height_r;
      DIV_X0:  div_a = ox0[DIM_W-1:0];
      DIV_X1:  div_a = ox1[DIM_W-1:0];
      DIV_Y0:  div_a = oy0[DIM_W-1:0];
      DIV_Y1:  div_a = oy1[DIM_W-1:0];
      default: div_a = '0;
    endcase
  end

  ogrp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (cell_size_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign div_q_inc = {1'b0, div_q} + {{DIM_W{1'b0}}, 1'b1};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_ok_r  <= 1'b1;
      col_last_r <= '0;
      row_last_r <= '0;
    end else if (cmd.grid_bad) begin
      grid_ok_r <= 1'b0;
    end else if (div_done && cmd.div_sel == DIV_VH) begin
      grid_ok_r  <= (col_q_r <= COL_LAST_Q) && (div_q <= ROW_LAST_Q);
      col_last_r <= col_q_r[COL_W-1:0];
      row_last_r <= div_q[ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd.div_sel)
        DIV_VW: col_q_r <= div_q;
        DIV_X0: c0_r    <= div_q[COL_W-1:0];
        DIV_X1: begin
          if (div_q_inc > {{(DIM_W+1-COL_W){1'b0}}, col_last_r}) begin
            c1_r <= col_last_r;
          end else begin
            c1_r <= div_q_inc[COL_W-1:0];
          end
        end
        DIV_Y0: r0_r <= div_q[ROW_W-1:0];
        DIV_Y1: begin
          if (div_q_inc > {{(DIM_W+1-ROW_W){1'b0}}, row_last_r}) begin
            r1_r <= row_last_r;
          end else begin
            r1_r <= div_q_inc[ROW_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mask_r <= (COL_ONES << c0_r) & (COL_ONES >> (COL_W'(MAX_COLS - 1) - c1_r));
  end

  // Row sweep over the occupancy memory, one row read per cycle.
  assign grid_clr = cmd.clear_grid || (cmd.cfg_write && cfg_idx_ok);
  assign occ_word = row_vld_r[rd_row_r] ? rdata_r : '0;
  assign hit_now  = rd_vld_r && !cmd.sweep_mark && ((occ_word & mask_r) != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r     <= 1'b0;
      row_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_row_r  <= '0;
      rd_last_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      rd_vld_r  <= act_r;
      rd_row_r  <= row_r;
      rd_last_r <= (row_r == r1_r);
      if (cmd.sweep_start) begin
        act_r <= 1'b1;
        row_r <= r0_r;
        hit_r <= 1'b0;
      end else begin
        if (act_r) begin
          if (row_r == r1_r) begin
            act_r <= 1'b0;
          end else begin
            row_r <= row_r + ROW_W'(1);
          end
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (grid_clr) begin
      row_vld_r <= '0;
    end else if (rd_vld_r && cmd.sweep_mark) begin
      row_vld_r[rd_row_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= occ_mem[row_r];
    if (rd_vld_r && cmd.sweep_mark) begin
      occ_mem[rd_row_r] <= occ_word | mask_r;
    end
  end

  // Result register on the output channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_data_r.shown  <= (cmd.result == ST_PLACED);
      out_data_r.status <= cmd.result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    st.cfg_idx_ok = cfg_idx_ok;
    st.cs_zero    = (cell_size_r == '0);
    st.kind_clear = item_r.kind;
    st.grid_ok    = grid_ok_r;
    st.empty      = (item_r.rect_width == '0) || (item_r.rect_height == '0) ||
                    (view_width_r == '0) || (view_height_r == '0);
    st.miss       = (x0_r > x1_r) || (y0_r > y1_r);
    st.div_busy   = div_busy;
    st.div_done   = div_done;
    st.sweep_busy = act_r || rd_vld_r;
    st.sweep_done = rd_vld_r && rd_last_r;
    st.hit        = hit_r || hit_now;
    st.out_free   = !out_valid_r || !out_stall;
  end

  `OGRP_ASSERT_IMP(a_mark_free, rd_vld_r && cmd.sweep_mark, (occ_word & mask_r) == '0, "mark pass found a taken cell")
  `OGRP_ASSERT_IMP(a_row_span, rd_vld_r, (rd_row_r >= r0_r) && (rd_row_r <= r1_r), "sweep row outside the span")
  `OGRP_ASSERT_NXT(a_div_pulse, div_done, !div_done, "divider done held longer than one cycle")
  `OGRP_ASSERT_IMP(a_no_overwrite, cmd.load_result, !out_valid_r || !out_stall, "pending result overwritten")

endmodule
`default_nettype wire

>>> src/ogrp_ctrl.sv
// Controller state machine that sequences configuration, clipping, division and row passes.
`default_nettype none
module ogrp_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  ogrp_pkg::ogrp_stat_t st,
  output ogrp_pkg::ogrp_cmd_t  cmd
);
  import ogrp_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_REBUILD = 13'b0000000000010,
    S_DIV_VW  = 13'b0000000000100,
    S_DIV_VH  = 13'b0000000001000,
    S_DECIDE  = 13'b0000000010000,
    S_CLIP    = 13'b0000000100000,
    S_DIV_X0  = 13'b0000001000000,
    S_DIV_X1  = 13'b0000010000000,
    S_DIV_Y0  = 13'b0000100000000,
    S_DIV_Y1  = 13'b0001000000000,
    S_CHECK   = 13'b0010000000000,
    S_MARK    = 13'b0100000000000,
    S_FINISH  = 13'b1000000000000
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;

  always_comb begin
    state_nxt       = state_r;
    res_nxt         = res_r;
    cmd.cfg_write   = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.clear_grid  = 1'b0;
    cmd.grid_bad    = 1'b0;
    cmd.div_start   = 1'b0;
    cmd.div_sel     = DIV_X0;
    cmd.sweep_start = 1'b0;
    cmd.sweep_mark  = 1'b0;
    cmd.load_result = 1'b0;
    cmd.result      = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_write = 1'b1;
          if (st.cfg_idx_ok) begin
            state_nxt = S_REBUILD;
          end
        end else if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECIDE;
        end
      end
      S_REBUILD: begin
        if (st.cs_zero) begin
          cmd.grid_bad = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_DIV_VW;
        end
      end
      S_DIV_VW: begin
        cmd.div_sel   = DIV_VW;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_DIV_VH;
        end
      end
      S_DIV_VH: begin
        cmd.div_sel   = DIV_VH;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_DECIDE: begin
        if (st.kind_clear) begin
          cmd.clear_grid = 1'b1;
          res_nxt        = st.grid_ok ? ST_CLEARED : ST_TOO_LARGE;
          state_nxt      = S_FINISH;
        end else if (!st.grid_ok) begin
          res_nxt   = ST_TOO_LARGE;
          state_nxt = S_FINISH;
        end else if (st.empty) begin
          res_nxt   = ST_OUTSIDE;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_CLIP;
        end
      end
      S_CLIP: begin
        if (st.miss) begin
          res_nxt   = ST_OUTSIDE;
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_DIV_X0;
        end
      end
      S_DIV_X0: begin
        cmd.div_sel   = DIV_X0;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_DIV_X1;
        end
      end
      S_DIV_X1: begin
        cmd.div_sel   = DIV_X1;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_DIV_Y0;
        end
      end
      S_DIV_Y0: begin
        cmd.div_sel   = DIV_Y0;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_DIV_Y1;
        end
      end
      S_DIV_Y1: begin
        cmd.div_sel   = DIV_Y1;
        cmd.div_start = !st.div_busy;
        if (st.div_done) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.sweep_start = !st.sweep_busy;
        if (st.sweep_done) begin
          if (st.hit) begin
            res_nxt   = ST_BLOCKED;
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.sweep_mark  = 1'b1;
        cmd.sweep_start = !st.sweep_busy;
        if (st.sweep_done) begin
          res_nxt   = ST_PLACED;
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_r   <= ST_PLACED;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/occupancy_grid_rect_placer.sv
// Top level of the occupancy grid rectangle placer.
// The block places rectangles greedily on a grid of up to 64 by 64 cells and answers each
// input item with one result. It works on one item at a time and takes no new item until the
// current one has reached the result register. For a place item that is accepted into the
// grid, four divisions by the cell size run on one shared divider that yields one quotient
// bit per cycle, then a check pass and a mark pass each read one row word per cycle from
// the occupancy memory. Rejected items finish sooner: a blocked item skips the mark pass,
// and items outside the view, clear items and items on a grid that is too large skip the
// divisions and both row passes. A configuration write to a valid index empties the grid
// at once and then computes the grid size, during which no transfer is taken on the input
// or configuration port.
`default_nettype none
module occupancy_grid_rect_placer (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  ogrp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output ogrp_pkg::out_item_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [ogrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [ogrp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ogrp_pkg::*;

  ogrp_cmd_t  cmd;
  ogrp_stat_t st;

  ogrp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .st        (st),
    .cmd       (cmd)
  );

  ogrp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the occupancy grid rectangle placer with a scoreboard class.
`timescale 1ns / 1ps

import ogrp_pkg::*;

class placer_checker;
  int vleft;
  int vtop;
  int vwid;
  int vhgt;
  int csize;
  int ncols;
  int nrows;
  bit grid_ok;
  logic [63:0] occ [MAX_ROWS];
  out_item_t verdicts [$];
  int faults;
  int tally [5];

  function new();
    vleft = 0;
    vtop = 0;
    vwid = 0;
    vhgt = 0;
    csize = 16;
    faults = 0;
    foreach (tally[i]) tally[i] = 0;
    rebuild_grid();
  endfunction

  function void rebuild_grid();
    foreach (occ[i]) occ[i] = '0;
    if (csize == 0) begin
      ncols = 0;
      nrows = 0;
      grid_ok = 1'b0;
      return;
    end
    ncols = vwid / csize + 1;
    nrows = vhgt / csize + 1;
    grid_ok = (ncols <= MAX_COLS) && (nrows <= MAX_ROWS);
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      CFG_VIEW_LEFT: vleft = $signed(d);
      CFG_VIEW_TOP: vtop = $signed(d);
      CFG_VIEW_WIDTH: vwid = int'(d[14:0]);
      CFG_VIEW_HEIGHT: vhgt = int'(d[14:0]);
      CFG_CELL_SIZE: csize = int'(d[12:0]);
      default: return;
    endcase
    rebuild_grid();
  endfunction

  function out_item_t predict_placement(in_item_t it);
    out_item_t v;
    int rl, rt, rw, rh;
    int x0, x1, y0, y1;
    int c0, c1, r0, r1, span, r;
    logic [63:0] mask;
    rl = $signed(it.rect_left);
    rt = $signed(it.rect_top);
    rw = int'(it.rect_width);
    rh = int'(it.rect_height);
    v.shown = 1'b0;
    if (it.kind) begin
      foreach (occ[i]) occ[i] = '0;
      v.status = grid_ok ? ST_CLEARED : ST_TOO_LARGE;
      return v;
    end
    if (!grid_ok) begin
      v.status = ST_TOO_LARGE;
      return v;
    end
    if (rw == 0 || rh == 0 || vwid == 0 || vhgt == 0) begin
      v.status = ST_OUTSIDE;
      return v;
    end
    x0 = (rl > vleft) ? rl : vleft;
    y0 = (rt > vtop) ? rt : vtop;
    x1 = rl + rw - 1;
    if (vleft + vwid - 1 < x1) x1 = vleft + vwid - 1;
    y1 = rt + rh - 1;
    if (vtop + vhgt - 1 < y1) y1 = vtop + vhgt - 1;
    if (x0 > x1 || y0 > y1) begin
      v.status = ST_OUTSIDE;
      return v;
    end
    c0 = (x0 - vleft) / csize;
    c1 = (x1 - vleft) / csize + 1;
    if (c1 > ncols - 1) c1 = ncols - 1;
    r0 = (y0 - vtop) / csize;
    r1 = (y1 - vtop) / csize + 1;
    if (r1 > nrows - 1) r1 = nrows - 1;
    span = (c1 - c0) & 63;
    mask = ({64{1'b1}} >> (63 - span)) << (c0 & 63);
    for (r = r0; r <= r1 && r < MAX_ROWS; r++) begin
      if ((occ[r] & mask) != '0) begin
        v.status = ST_BLOCKED;
        return v;
      end
    end
    for (r = r0; r <= r1 && r < MAX_ROWS; r++) occ[r] = occ[r] | mask;
    v.shown = 1'b1;
    v.status = ST_PLACED;
    return v;
  endfunction

  task note_item(in_item_t it);
    out_item_t v;
    v = predict_placement(it);
    verdicts.insert(verdicts.size(), v);
    tally[v.status]++;
  endtask

  task report(string msg);
    if (faults < 30) $display("%0t MISMATCH: %s", $realtime, msg);
    faults++;
  endtask

  task check_verdict(out_item_t got);
    out_item_t want;
    if (verdicts.size() == 0) begin
      report($sformatf("result transfer with no item outstanding (shown %0d status %0d)",
                       got.shown, got.status));
      return;
    end
    want = verdicts.pop_front();
    if (got.shown !== want.shown)
      report($sformatf("shown is %0d, expected %0d", got.shown, want.shown));
    if (got.status !== want.status)
      report($sformatf("status is %0d, expected %0d", got.status, want.status));
  endtask

  function int pending();
    return verdicts.size();
  endfunction
endclass

module tb_top;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd5;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  placer_checker board;
  bit calm;
  int items_sent;
  int cfg_writes;

  occupancy_grid_rect_placer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #6000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t rect(bit k, int l, int t, int w, int h);
    in_item_t it;
    it.kind = k;
    it.rect_left = 16'(l);
    it.rect_top = 16'(t);
    it.rect_width = 15'(w);
    it.rect_height = 15'(h);
    return it;
  endfunction

  function automatic in_item_t make_item();
    in_item_t it;
    int p, off, cs, span;
    cs = (board.csize == 0) ? 16 : board.csize;
    it.kind = 1'b0;
    it.rect_left = 16'($urandom);
    it.rect_top = 16'($urandom);
    it.rect_width = 15'($urandom);
    it.rect_height = 15'($urandom);
    p = $urandom_range(0, 99);
    if (p < 6) begin
      it.kind = 1'b1;
    end else if (p < 16) begin
      it.kind = 1'($urandom);
    end else begin
      off = int'($urandom_range(0, board.vwid + 2 * cs)) - cs;
      it.rect_left = 16'(board.vleft + off);
      off = int'($urandom_range(0, board.vhgt + 2 * cs)) - cs;
      it.rect_top = 16'(board.vtop + off);
      span = (p < 90) ? 2 * cs : 12 * cs;
      if (span > 32767) span = 32767;
      it.rect_width = 15'($urandom_range(1, span));
      it.rect_height = 15'($urandom_range(1, span));
      if (p == 98) it.rect_width = '0;
      if (p == 99) it.rect_height = '0;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it, bit last);
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
    items_sent++;
    @(negedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0 || last) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_view(int vl, int vt, int vw, int vh, int cs);
    write_reg(CFG_VIEW_LEFT, 16'(vl));
    write_reg(CFG_VIEW_TOP, 16'(vt));
    write_reg(CFG_VIEW_WIDTH, 16'(vw));
    write_reg(CFG_VIEW_HEIGHT, 16'(vh));
    write_reg(CFG_CELL_SIZE, 16'(cs));
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic random_config();
    int cs, cols, rows, vw, vh, m, r;
    m = $urandom_range(0, 19);
    r = $urandom_range(0, 9);
    if (r < 4) cs = $urandom_range(1, 8);
    else if (r < 7) cs = $urandom_range(9, 512);
    else cs = $urandom_range(513, 8191);
    cols = $urandom_range(1, 64);
    rows = $urandom_range(1, 64);
    if (m == 1) cols = $urandom_range(65, 130);
    if (m == 2) rows = $urandom_range(65, 130);
    vw = (cols - 1) * cs + int'($urandom_range(0, cs - 1));
    vh = (rows - 1) * cs + int'($urandom_range(0, cs - 1));
    if (vw > 32767) vw = 32767;
    if (vh > 32767) vh = 32767;
    if (m == 3) vw = 0;
    if (m == 4) vh = 0;
    if (m == 0) cs = 0;
    write_reg(CFG_VIEW_LEFT, 16'($urandom));
    write_reg(CFG_VIEW_TOP, 16'($urandom));
    write_reg(CFG_VIEW_WIDTH, 16'(vw) | 16'($urandom_range(0, 1) << 15));
    write_reg(CFG_VIEW_HEIGHT, 16'(vh) | 16'($urandom_range(0, 1) << 15));
    write_reg(CFG_CELL_SIZE, 16'(cs) | 16'($urandom_range(0, 7) << 13));
    if (m == 5) write_reg(3'($urandom_range(CFG_UNUSED_IDX, 7)), 16'($urandom));
  endtask

  initial begin
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) board.check_verdict(out_data);
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
        if (!calm) hold = pick_gap();
      end
    end
  end

  initial begin
    int n, k, waited;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    board = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The view after reset is empty, so a place is outside and a clear still works.
    send_item(rect(1'b0, 0, 0, 10, 10), 1'b0);
    send_item(rect(1'b1, 0, 0, 0, 0), 1'b1);
    wait_idle();

    apply_view(-100, 50, 639, 479, 16);
    send_item(rect(1'b0, -32768, -32768, 32767, 32767), 1'b0);
    send_item(rect(1'b0, -100, 50, 1, 1), 1'b0);
    send_item(rect(1'b0, -100, 50, 1, 1), 1'b0);
    send_item(rect(1'b0, 538, 528, 1, 1), 1'b0);
    send_item(rect(1'b0, 539, 200, 5, 5), 1'b0);
    send_item(rect(1'b0, -101, 200, 1, 5), 1'b0);
    send_item(rect(1'b0, 0, 100, 0, 20), 1'b0);
    send_item(rect(1'b0, 0, 100, 20, 0), 1'b0);
    send_item(rect(1'b0, 32767, 32767, 32767, 32767), 1'b0);
    send_item(rect(1'b0, 0, 100, 32767, 100), 1'b0);
    send_item(rect(1'b1, 0, 0, 0, 0), 1'b0);
    send_item(rect(1'b0, -100, 50, 640, 480), 1'b1);
    wait_idle();

    write_reg(CFG_CELL_SIZE, 16'd0);
    send_item(rect(1'b0, 0, 0, 5, 5), 1'b0);
    send_item(rect(1'b1, 0, 0, 0, 0), 1'b1);
    wait_idle();

    apply_view(-32768, 32767, 32767, 32767, 4096);
    send_item(rect(1'b0, -32768, 32767, 32767, 32767), 1'b0);
    send_item(rect(1'b0, -32768, 32767, 32767, 32767), 1'b1);
    wait_idle();

    apply_view(0, 0, 63, 63, 1);
    send_item(rect(1'b0, 0, 0, 64, 64), 1'b0);
    send_item(rect(1'b0, 63, 63, 1, 1), 1'b1);
    wait_idle();
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    send_item(rect(1'b0, 63, 63, 1, 1), 1'b1);
    wait_idle();
    write_reg(CFG_VIEW_WIDTH, 16'd64);
    send_item(rect(1'b0, 0, 0, 1, 1), 1'b1);
    wait_idle();

    while (items_sent < 1300) begin
      random_config();
      calm = ($urandom_range(0, 5) == 0);
      n = $urandom_range(20, 80);
      for (k = 0; k < n; k++) send_item(make_item(), k == n - 1);
      wait_idle();
    end

    calm = 1'b0;
    waited = 0;
    while (board.pending() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (250) @(negedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d results never arrived", board.pending()));

    $display("Sent %0d items under %0d register writes: %0d placed, %0d blocked, %0d outside.",
             items_sent, cfg_writes, board.tally[ST_PLACED], board.tally[ST_BLOCKED],
             board.tally[ST_OUTSIDE]);
    $display("Grid clears answered: %0d; items on an oversized or zero-cell grid: %0d.",
             board.tally[ST_CLEARED], board.tally[ST_TOO_LARGE]);
    if (board.faults == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
